FILE: src/gdd_pkg.sv
// Shared types, constants and tables of the GMSK discriminator demodulator.
`timescale 1ns / 1ps
package gdd_pkg;

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 12;
  localparam int SPS_W      = 12;
  localparam int TAPS_W     = 10;
  localparam int SAMPLE_W   = 16;
  localparam int TIDX_W     = 9;
  localparam int TVAL_W     = 16;
  localparam int COEF_W     = 17;
  localparam int SUM_W      = 28;
  localparam int CORDIC_N   = 24;
  localparam int K_W        = 5;
  localparam logic [TVAL_W-1:0] COEF_ONE = 16'd32768;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_SPS  = 2'd0,
    REG_TAPS = 2'd1
  } gdd_reg_e;

  typedef enum logic [3:0] {
    S_INIT,
    S_CLEAR,
    S_IDLE,
    S_LOAD,
    S_PROD,
    S_CINIT,
    S_CORDIC,
    S_WRITE,
    S_MAC,
    S_DRAIN,
    S_POST,
    S_EMIT
  } gdd_state_e;

  typedef struct packed {
    logic in_ready;
    logic capture;
    logic sweep_init;
    logic sweep_step;
    logic sweep_coef;
    logic coef_write;
    logic prod_step;
    logic cordic_init;
    logic cordic_step;
    logic angle_write;
    logic mac_issue;
    logic post;
    logic emit;
  } gdd_cmd_t;

  typedef struct packed {
    logic in_valid;
    logic in_action;
    logic cfg_clear;
    logic sweep_done;
    logic prod_done;
    logic cordic_done;
    logic mac_last;
    logic pipe_busy;
    logic has_result;
    logic out_free;
  } gdd_stat_t;

  // arctangent of 2^-k in units of 2^32 per turn
  function automatic logic [31:0] atan_turn(input logic [K_W-1:0] k);
    logic [31:0] r;
    case (k)
      5'd0:  r = 32'd536870912;
      5'd1:  r = 32'd316933406;
      5'd2:  r = 32'd167458907;
      5'd3:  r = 32'd85004756;
      5'd4:  r = 32'd42667331;
      5'd5:  r = 32'd21354465;
      5'd6:  r = 32'd10679838;
      5'd7:  r = 32'd5340245;
      5'd8:  r = 32'd2670163;
      5'd9:  r = 32'd1335087;
      5'd10: r = 32'd667544;
      5'd11: r = 32'd333772;
      5'd12: r = 32'd166886;
      5'd13: r = 32'd83443;
      5'd14: r = 32'd41722;
      5'd15: r = 32'd20861;
      5'd16: r = 32'd10430;
      5'd17: r = 32'd5215;
      5'd18: r = 32'd2608;
      5'd19: r = 32'd1304;
      5'd20: r = 32'd652;
      5'd21: r = 32'd326;
      5'd22: r = 32'd163;
      5'd23: r = 32'd81;
      default: r = 32'd0;
    endcase
    return r;
  endfunction

endpackage

FILE: src/gdd_in_if.sv
// Input request channel: IQ samples and coefficient loads.
`timescale 1ns / 1ps
interface gdd_in_if;
  logic                                  valid;
  logic                                  ready;
  logic                                  action;
  logic signed [gdd_pkg::SAMPLE_W-1:0]   i_sample;
  logic signed [gdd_pkg::SAMPLE_W-1:0]   q_sample;
  logic        [gdd_pkg::TIDX_W-1:0]     tap_index;
  logic        [gdd_pkg::TVAL_W-1:0]     tap_value;

  modport source (output valid, action, i_sample, q_sample, tap_index, tap_value,
                  input ready);
  modport sink (input valid, action, i_sample, q_sample, tap_index, tap_value,
                output ready);
endinterface

FILE: src/gdd_out_if.sv
// Output request channel: decided bits and symbol sums.
`timescale 1ns / 1ps
interface gdd_out_if;
  logic                               valid;
  logic                               ready;
  logic                               bit_res;
  logic signed [gdd_pkg::SUM_W-1:0]   symbol_sum;

  modport source (output valid, bit_res, symbol_sum, input ready);
  modport sink (input valid, bit_res, symbol_sum, output ready);
endinterface

FILE: src/gdd_ctrl.sv
// Sequencer of the demodulator: clearing passes, sample processing, result hand-off.
`timescale 1ns / 1ps
module gdd_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  gdd_pkg::gdd_stat_t stat_i,
  output gdd_pkg::gdd_cmd_t  cmd_o
);

  gdd_pkg::gdd_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= gdd_pkg::S_INIT;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    if (stat_i.cfg_clear) begin
      // restart the delay line sweep; keep the coefficient sweep after reset
      cmd_o.sweep_init = 1'b1;
      state_d = (state_q == gdd_pkg::S_INIT) ? gdd_pkg::S_INIT : gdd_pkg::S_CLEAR;
    end else begin
      unique case (state_q)
        gdd_pkg::S_INIT: begin
          cmd_o.sweep_step = 1'b1;
          cmd_o.sweep_coef = 1'b1;
          if (stat_i.sweep_done) state_d = gdd_pkg::S_IDLE;
        end
        gdd_pkg::S_CLEAR: begin
          cmd_o.sweep_step = 1'b1;
          if (stat_i.sweep_done) state_d = gdd_pkg::S_IDLE;
        end
        gdd_pkg::S_IDLE: begin
          cmd_o.in_ready = 1'b1;
          if (stat_i.in_valid) begin
            cmd_o.capture = 1'b1;
            state_d = stat_i.in_action ? gdd_pkg::S_LOAD : gdd_pkg::S_PROD;
          end
        end
        gdd_pkg::S_LOAD: begin
          cmd_o.coef_write = 1'b1;
          state_d = gdd_pkg::S_IDLE;
        end
        gdd_pkg::S_PROD: begin
          cmd_o.prod_step = 1'b1;
          if (stat_i.prod_done) state_d = gdd_pkg::S_CINIT;
        end
        gdd_pkg::S_CINIT: begin
          cmd_o.cordic_init = 1'b1;
          state_d = gdd_pkg::S_CORDIC;
        end
        gdd_pkg::S_CORDIC: begin
          cmd_o.cordic_step = 1'b1;
          if (stat_i.cordic_done) state_d = gdd_pkg::S_WRITE;
        end
        gdd_pkg::S_WRITE: begin
          cmd_o.angle_write = 1'b1;
          state_d = gdd_pkg::S_MAC;
        end
        gdd_pkg::S_MAC: begin
          cmd_o.mac_issue = 1'b1;
          if (stat_i.mac_last) state_d = gdd_pkg::S_DRAIN;
        end
        gdd_pkg::S_DRAIN: begin
          if (!stat_i.pipe_busy) state_d = gdd_pkg::S_POST;
        end
        gdd_pkg::S_POST: begin
          cmd_o.post = 1'b1;
          state_d = stat_i.has_result ? gdd_pkg::S_EMIT : gdd_pkg::S_IDLE;
        end
        gdd_pkg::S_EMIT: begin
          // hold the result until the output register frees up
          if (stat_i.out_free) begin
            cmd_o.emit = 1'b1;
            state_d = gdd_pkg::S_IDLE;
          end
        end
        default: state_d = gdd_pkg::S_INIT;
      endcase
    end
  end

endmodule

FILE: src/gdd_cordic.sv
// Iterative vectoring CORDIC: phase of (dot, cross) as a binary angle.
`timescale 1ns / 1ps
module gdd_cordic #(
  parameter int ANGLE_BITS = 16
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         init_i,
  input  logic                         step_i,
  input  logic signed [33:0]           cross_i,
  input  logic signed [33:0]           dot_i,
  output logic                         done_o,
  output logic signed [ANGLE_BITS-1:0] angle_o
);

  localparam int SH = 32 - ANGLE_BITS;

  logic signed [35:0]         x_q, y_q;
  logic [31:0]                z_q;
  logic [gdd_pkg::K_W-1:0]    k_q;
  logic                       zero_q, neg_q;
  logic signed [35:0]         xs, ys;
  logic [31:0]                zr;
  logic [ANGLE_BITS-1:0]      r;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      k_q <= '0;
    end else if (init_i) begin
      k_q <= '0;
    end else if (step_i) begin
      k_q <= k_q + 1'b1;
    end
  end

  assign xs = x_q >>> k_q;
  assign ys = y_q >>> k_q;

  always_ff @(posedge clk_i) begin
    if (init_i) begin
      zero_q <= (cross_i == '0) && (dot_i == '0);
      neg_q  <= cross_i < 0;
      // pre-rotate by pi into the right half plane
      if (dot_i < 0) begin
        x_q <= -36'(dot_i);
        y_q <= -36'(cross_i);
        z_q <= 32'h8000_0000;
      end else begin
        x_q <= 36'(dot_i);
        y_q <= 36'(cross_i);
        z_q <= '0;
      end
    end else if (step_i) begin
      if (y_q >= 0) begin
        x_q <= x_q + ys;
        y_q <= y_q - xs;
        z_q <= z_q + gdd_pkg::atan_turn(k_q);
      end else begin
        x_q <= x_q - ys;
        y_q <= y_q + xs;
        z_q <= z_q - gdd_pkg::atan_turn(k_q);
      end
    end
  end

  assign done_o = (k_q == gdd_pkg::K_W'(gdd_pkg::CORDIC_N - 1));
  assign zr     = z_q + (32'd1 << (SH - 1));
  assign r      = zr[31:SH];

  always_comb begin
    if (zero_q) begin
      angle_o = '0;
    end else if (!neg_q && r == {1'b1, {(ANGLE_BITS-1){1'b0}}}) begin
      // plus pi maps to the most positive code
      angle_o = {1'b0, {(ANGLE_BITS-1){1'b1}}};
    end else begin
      angle_o = signed'(r);
    end
  end

endmodule

FILE: src/gdd_datapath.sv
// Datapath: cross/dot products, CORDIC, FIR memories and MAC, symbol integrator.
`timescale 1ns / 1ps
module gdd_datapath #(
  parameter int MAX_TAPS   = 512,
  parameter int ANGLE_BITS = 16
) (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  gdd_pkg::gdd_cmd_t                      cmd_i,
  output gdd_pkg::gdd_stat_t                     stat_o,
  input  logic                                   cfg_we_i,
  input  logic [gdd_pkg::CFG_IDX_W-1:0]          cfg_idx_i,
  input  logic [gdd_pkg::CFG_DATA_W-1:0]         cfg_data_i,
  input  logic                                   in_valid_i,
  input  logic                                   in_action_i,
  input  logic signed [gdd_pkg::SAMPLE_W-1:0]    in_i_i,
  input  logic signed [gdd_pkg::SAMPLE_W-1:0]    in_q_i,
  input  logic [gdd_pkg::TIDX_W-1:0]             in_tidx_i,
  input  logic [gdd_pkg::TVAL_W-1:0]             in_tval_i,
  input  logic                                   out_ready_i,
  output logic                                   out_valid_o,
  output logic                                   out_bit_o,
  output logic signed [gdd_pkg::SUM_W-1:0]       out_sum_o
);

  localparam int AW  = (MAX_TAPS > 1) ? $clog2(MAX_TAPS) : 1;
  localparam int LW  = $clog2(MAX_TAPS + 1);
  localparam int CW  = AW + 1;
  localparam int PW  = gdd_pkg::COEF_W + 1 + ANGLE_BITS;
  localparam int ACW = PW + AW + 1;
  localparam int SW  = gdd_pkg::SUM_W;
  localparam longint OMAX = (64'sd1 <<< (ANGLE_BITS - 1)) - 1;
  localparam longint OMIN = -OMAX - 1;

  // configuration
  logic [gdd_pkg::SPS_W-1:0]  sps_q;
  logic [gdd_pkg::TAPS_W-1:0] taps_q;
  logic                       cfg_clear;
  logic [LW-1:0]              len;

  assign cfg_clear = cfg_we_i && (cfg_idx_i == gdd_pkg::REG_SPS ||
                                  cfg_idx_i == gdd_pkg::REG_TAPS);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sps_q  <= 12'd213;
      taps_q <= 10'd1;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        gdd_pkg::REG_SPS:  sps_q  <= cfg_data_i[gdd_pkg::SPS_W-1:0];
        gdd_pkg::REG_TAPS: taps_q <= cfg_data_i[gdd_pkg::TAPS_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    if (taps_q == '0) begin
      len = LW'(1);
    end else if (int'(taps_q) > MAX_TAPS) begin
      len = LW'(MAX_TAPS);
    end else begin
      len = LW'(taps_q);
    end
  end

  // captured request
  logic signed [gdd_pkg::SAMPLE_W-1:0] is_q, qs_q, pi_q, pq_q;
  logic [gdd_pkg::TIDX_W-1:0]         tidx_q;
  logic [gdd_pkg::TVAL_W-1:0]         tval_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      is_q   <= in_i_i;
      qs_q   <= in_q_i;
      tidx_q <= in_tidx_i;
      tval_q <= in_tval_i;
    end
  end

  // cross and dot, one product per cycle
  logic [1:0]          p_q;
  logic signed [15:0]  ma, mb;
  logic signed [31:0]  mp;
  logic signed [33:0]  cross_q, dot_q;

  always_comb begin
    case (p_q)
      2'd0:    begin ma = is_q; mb = pi_q; end
      2'd1:    begin ma = qs_q; mb = pq_q; end
      2'd2:    begin ma = qs_q; mb = pi_q; end
      default: begin ma = is_q; mb = pq_q; end
    endcase
  end
  assign mp = ma * mb;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      p_q  <= '0;
      pi_q <= '0;
      pq_q <= '0;
    end else if (cmd_i.capture) begin
      p_q <= '0;
    end else if (cmd_i.prod_step) begin
      p_q <= p_q + 1'b1;
      if (p_q == 2'd3) begin
        pi_q <= is_q;
        pq_q <= qs_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.prod_step) begin
      case (p_q)
        2'd0:    dot_q   <= 34'(mp);
        2'd1:    dot_q   <= dot_q + 34'(mp);
        2'd2:    cross_q <= 34'(mp);
        default: cross_q <= cross_q - 34'(mp);
      endcase
    end
  end

  logic                         cordic_done;
  logic signed [ANGLE_BITS-1:0] angle;

  gdd_cordic #(
    .ANGLE_BITS (ANGLE_BITS)
  ) u_cordic (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .init_i  (cmd_i.cordic_init),
    .step_i  (cmd_i.cordic_step),
    .cross_i (cross_q),
    .dot_i   (dot_q),
    .done_o  (cordic_done),
    .angle_o (angle)
  );

  // clearing sweep and FIR addressing
  logic [AW-1:0] sweep_q, wp_q, bi_q, t_q, wp_eff, wp_nxt, bi_nxt;
  logic [CW-1:0] wp_inc, bi_inc;
  logic          sweep_done, mac_last;

  assign sweep_done = (sweep_q == AW'(MAX_TAPS - 1));
  assign wp_eff     = (CW'(wp_q) >= CW'(len)) ? '0 : wp_q;
  assign wp_inc     = CW'(wp_eff) + 1'b1;
  assign wp_nxt     = (wp_inc >= CW'(len)) ? '0 : wp_inc[AW-1:0];
  assign bi_inc     = CW'(bi_q) + 1'b1;
  assign bi_nxt     = (bi_inc >= CW'(len)) ? '0 : bi_inc[AW-1:0];
  assign mac_last   = (CW'(t_q) == CW'(len) - 1'b1);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sweep_q <= '0;
      wp_q    <= '0;
      bi_q    <= '0;
      t_q     <= '0;
    end else begin
      if (cmd_i.sweep_init) begin
        sweep_q <= '0;
      end else if (cmd_i.sweep_step) begin
        sweep_q <= sweep_q + 1'b1;
      end
      if (cfg_clear) begin
        wp_q <= '0;
      end else if (cmd_i.angle_write) begin
        wp_q <= wp_nxt;
      end
      if (cmd_i.angle_write) begin
        bi_q <= wp_nxt;
        t_q  <= '0;
      end else if (cmd_i.mac_issue) begin
        bi_q <= bi_nxt;
        t_q  <= t_q + 1'b1;
      end
    end
  end

  // memories
  logic [gdd_pkg::COEF_W-1:0]   coef_mem [MAX_TAPS];
  logic [ANGLE_BITS-1:0]        dly_mem  [MAX_TAPS];
  logic [gdd_pkg::COEF_W-1:0]   coef_rd_q;
  logic [ANGLE_BITS-1:0]        dly_rd_q;
  logic [gdd_pkg::TVAL_W-1:0]   tval_sat;

  assign tval_sat = (tval_q > gdd_pkg::COEF_ONE) ? gdd_pkg::COEF_ONE : tval_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.sweep_step && cmd_i.sweep_coef) begin
      coef_mem[sweep_q] <= (sweep_q == '0) ? gdd_pkg::COEF_W'(gdd_pkg::COEF_ONE) : '0;
    end else if (cmd_i.coef_write && int'(tidx_q) < MAX_TAPS) begin
      coef_mem[AW'(tidx_q)] <= gdd_pkg::COEF_W'(tval_sat);
    end
    if (cmd_i.mac_issue) begin
      coef_rd_q <= coef_mem[t_q];
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.sweep_step) begin
      dly_mem[sweep_q] <= '0;
    end else if (cmd_i.angle_write) begin
      dly_mem[wp_eff] <= angle;
    end
    if (cmd_i.mac_issue) begin
      dly_rd_q <= dly_mem[bi_q];
    end
  end

  // multiply-accumulate pipeline
  logic                  rd_v_q, pv_q;
  logic signed [PW-1:0]  prod_q;
  logic signed [ACW-1:0] acc_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_v_q <= 1'b0;
      pv_q   <= 1'b0;
    end else begin
      rd_v_q <= cmd_i.mac_issue;
      pv_q   <= rd_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    prod_q <= $signed({1'b0, coef_rd_q}) * $signed(dly_rd_q);
    if (cmd_i.angle_write) begin
      acc_q <= '0;
    end else if (pv_q) begin
      acc_q <= acc_q + ACW'(prod_q);
    end
  end

  // rounding, saturation and symbol integration
  logic signed [ACW-1:0]        acc_rnd;
  logic signed [ANGLE_BITS-1:0] filt;
  logic signed [SW:0]           rs_wide;
  logic signed [SW-1:0]         rs_q, rs_sat;
  logic [gdd_pkg::SPS_W-1:0]    sc_q, sc_nxt, sps_eff;
  logic                         hit;
  logic                         res_bit_q;
  logic signed [SW-1:0]         res_sum_q;

  assign acc_rnd = (acc_q + ACW'(16384)) >>> 15;

  always_comb begin
    if (acc_rnd > signed'(ACW'(OMAX))) begin
      filt = signed'(ANGLE_BITS'(OMAX));
    end else if (acc_rnd < signed'(ACW'(OMIN))) begin
      filt = signed'(ANGLE_BITS'(OMIN));
    end else begin
      filt = signed'(acc_rnd[ANGLE_BITS-1:0]);
    end
  end

  assign rs_wide = (SW+1)'(rs_q) + (SW+1)'(filt);

  always_comb begin
    if (rs_wide[SW] != rs_wide[SW-1]) begin
      rs_sat = rs_wide[SW] ? {1'b1, {(SW-1){1'b0}}} : {1'b0, {(SW-1){1'b1}}};
    end else begin
      rs_sat = rs_wide[SW-1:0];
    end
  end

  assign sps_eff = (sps_q == '0) ? 12'd1 : sps_q;
  assign sc_nxt  = sc_q + 1'b1;
  assign hit     = (sc_nxt >= sps_eff);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sc_q <= '0;
      rs_q <= '0;
    end else if (cfg_clear) begin
      sc_q <= '0;
      rs_q <= '0;
    end else if (cmd_i.post) begin
      sc_q <= hit ? '0 : sc_nxt;
      rs_q <= hit ? '0 : rs_sat;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.post && hit) begin
      res_bit_q <= (rs_sat > 0);
      res_sum_q <= rs_sat;
    end
  end

  // output register
  logic                 out_valid_q, out_bit_q;
  logic signed [SW-1:0] out_sum_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.emit) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.emit) begin
      out_bit_q <= res_bit_q;
      out_sum_q <= res_sum_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_bit_o   = out_bit_q;
  assign out_sum_o   = out_sum_q;

  always_comb begin
    stat_o             = '0;
    stat_o.in_valid    = in_valid_i;
    stat_o.in_action   = in_action_i;
    stat_o.cfg_clear   = cfg_clear;
    stat_o.sweep_done  = sweep_done;
    stat_o.prod_done   = (p_q == 2'd3);
    stat_o.cordic_done = cordic_done;
    stat_o.mac_last    = mac_last;
    stat_o.pipe_busy   = rd_v_q || pv_q;
    stat_o.has_result  = hit;
    stat_o.out_free    = !out_valid_q || out_ready_i;
  end

  wp_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.angle_write |=> (CW'(wp_q) < CW'(len)))
    else $error("write position beyond tap count");

  symbol_restart: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.post && hit && !cfg_clear) |=> (sc_q == '0 && rs_q == '0))
    else $error("integrator not restarted after symbol");

  emit_needs_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.emit |-> (!out_valid_q || out_ready_i))
    else $error("result overwrote a pending output");

  mac_not_during_write: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.mac_issue |-> !(cmd_i.angle_write || cmd_i.sweep_step))
    else $error("tap read overlaps a delay line write");

endmodule

FILE: src/gmsk_discriminator_demod_core.sv
// GMSK discriminator demodulator top level: channels, configuration port, sequencer and datapath.
`timescale 1ns / 1ps
// One request at a time. A coefficient load is captured and written to the coefficient
// memory before the next request can be taken. An IQ sample passes, from acceptance until
// the next request can be taken, through: capture, four cross/dot products on one 16x16
// multiplier, CORDIC set-up, 24 CORDIC iterations, a delay line write, then one tap per cycle
// over len taps, where len is the tap count held to 1..MAX_TAPS, through the single read port
// of each FIR memory and one shared multiply-accumulate, a drain of the read and product
// registers and an integrator update. A sample that closes a symbol then passes an emit step
// to hand its result over. A request is taken while an earlier result still waits in the
// output register; only a second result stalls until it is taken. After reset, and after each
// write of the symbol length or tap count register, a clearing pass runs over all MAX_TAPS
// delay line entries (after reset also the coefficients), during which no request is taken.
module gmsk_discriminator_demod_core #(
  parameter int MAX_TAPS   = 512,
  parameter int ANGLE_BITS = 16
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  gdd_in_if.sink                          in_if,
  gdd_out_if.source                       out_if,
  input  logic                            cfg_we_i,
  input  logic [gdd_pkg::CFG_IDX_W-1:0]   cfg_idx_i,
  input  logic [gdd_pkg::CFG_DATA_W-1:0]  cfg_data_i
);

  gdd_pkg::gdd_cmd_t  cmd;
  gdd_pkg::gdd_stat_t stat;

  gdd_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .stat_i (stat),
    .cmd_o  (cmd)
  );

  gdd_datapath #(
    .MAX_TAPS   (MAX_TAPS),
    .ANGLE_BITS (ANGLE_BITS)
  ) u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .stat_o      (stat),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_data_i  (cfg_data_i),
    .in_valid_i  (in_if.valid),
    .in_action_i (in_if.action),
    .in_i_i      (in_if.i_sample),
    .in_q_i      (in_if.q_sample),
    .in_tidx_i   (in_if.tap_index),
    .in_tval_i   (in_if.tap_value),
    .out_ready_i (out_if.ready),
    .out_valid_o (out_if.valid),
    .out_bit_o   (out_if.bit_res),
    .out_sum_o   (out_if.symbol_sum)
  );

  assign in_if.ready = cmd.in_ready;

endmodule

FILE: bench/gmsk_discriminator_demod_core_test.sv
// Self-checking testbench of the GMSK discriminator demodulator core.
`timescale 1ns / 1ps
module gmsk_discriminator_demod_core_test;

  localparam int TAP_DEPTH = 512;
  localparam int SETTLE_CYCLES = 600;

  typedef struct {
    bit                                  is_load;
    logic signed [gdd_pkg::SAMPLE_W-1:0] i_val;
    logic signed [gdd_pkg::SAMPLE_W-1:0] q_val;
    logic [gdd_pkg::TIDX_W-1:0]          slot;
    logic [gdd_pkg::TVAL_W-1:0]          coef;
  } demod_req_t;

  typedef struct {
    bit                               decided;
    logic signed [gdd_pkg::SUM_W-1:0] total;
  } symbol_t;

  class demod_scoreboard;
    int unsigned sps_reg, taps_reg;
    int          last_i, last_q;
    int          coef_mem[TAP_DEPTH];
    int          angle_mem[TAP_DEPTH];
    int unsigned wr_pos, sample_cnt;
    longint      acc_sum;
    symbol_t     symbols_due[$];
    int          errors;
    bit [31:0]   atan_tab[gdd_pkg::CORDIC_N];

    function new();
      atan_tab = '{32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756,
                   32'd42667331, 32'd21354465, 32'd10679838, 32'd5340245,
                   32'd2670163, 32'd1335087, 32'd667544, 32'd333772,
                   32'd166886, 32'd83443, 32'd41722, 32'd20861, 32'd10430,
                   32'd5215, 32'd2608, 32'd1304, 32'd652, 32'd326, 32'd163, 32'd81};
      sps_reg = 213;
      taps_reg = 1;
      last_i = 0;
      last_q = 0;
      foreach (coef_mem[k]) coef_mem[k] = 0;
      coef_mem[0] = 32768;
      errors = 0;
      flush();
    endfunction

    function void flush();
      foreach (angle_mem[k]) angle_mem[k] = 0;
      wr_pos = 0;
      sample_cnt = 0;
      acc_sum = 0;
    endfunction

    function void set_reg(gdd_pkg::gdd_reg_e r, int unsigned v);
      if (r == gdd_pkg::REG_SPS) sps_reg = v & 12'hFFF;
      else taps_reg = v & 10'h3FF;
      flush();
    endfunction

    function int phase_step(longint xprod, longint dot);
      longint    x, y, nx, ny;
      bit [31:0] z, r;
      int        a;
      if (xprod == 0 && dot == 0) return 0;
      x = dot;
      y = xprod;
      z = 0;
      if (x < 0) begin
        x = -x;
        y = -y;
        z = 32'h8000_0000;
      end
      for (int k = 0; k < gdd_pkg::CORDIC_N; k++) begin
        if (y >= 0) begin
          nx = x + (y >>> k);
          ny = y - (x >>> k);
          z = z + atan_tab[k];
        end else begin
          nx = x - (y >>> k);
          ny = y + (x >>> k);
          z = z - atan_tab[k];
        end
        x = nx;
        y = ny;
      end
      r = (z + 32'h8000) >> 16;
      a = $signed(r[15:0]);
      // a step of exactly plus pi keeps its sign
      if (xprod >= 0 && a == -32768) a = 32767;
      return a;
    endfunction

    function void note_request(demod_req_t q);
      longint      xprod, dot, acc, filt;
      int          ang, len, sps, bi;
      symbol_t     s;
      if (q.is_load) begin
        coef_mem[q.slot] = (q.coef > 16'd32768) ? 32768 : int'(q.coef);
        return;
      end
      xprod = longint'(q.q_val) * last_i - longint'(q.i_val) * last_q;
      dot = longint'(q.i_val) * last_i + longint'(q.q_val) * last_q;
      ang = phase_step(xprod, dot);
      last_i = q.i_val;
      last_q = q.q_val;
      len = (taps_reg == 0) ? 1 : (taps_reg > TAP_DEPTH) ? TAP_DEPTH : taps_reg;
      if (wr_pos >= len) wr_pos = 0;
      angle_mem[wr_pos] = ang;
      wr_pos++;
      if (wr_pos >= len) wr_pos = 0;
      acc = 0;
      bi = wr_pos;
      for (int t = 0; t < len; t++) begin
        acc += longint'(coef_mem[t]) * angle_mem[bi];
        bi++;
        if (bi >= len) bi = 0;
      end
      filt = (acc + 16384) >>> 15;
      if (filt > 32767) filt = 32767;
      if (filt < -32768) filt = -32768;
      acc_sum += filt;
      if (acc_sum > 134217727) acc_sum = 134217727;
      if (acc_sum < -134217728) acc_sum = -134217728;
      sps = (sps_reg == 0) ? 1 : sps_reg;
      sample_cnt = (sample_cnt + 1) & 12'hFFF;
      if (sample_cnt >= sps) begin
        s.decided = acc_sum > 0;
        s.total = acc_sum[gdd_pkg::SUM_W-1:0];
        symbols_due.push_back(s);
        sample_cnt = 0;
        acc_sum = 0;
      end
    endfunction

    function void check_result(bit b, logic signed [gdd_pkg::SUM_W-1:0] sum);
      symbol_t s;
      if (symbols_due.size() == 0) begin
        $error("unexpected symbol: bit_res %0d symbol_sum %0d", b, sum);
        errors++;
        return;
      end
      s = symbols_due.pop_front();
      if (b !== s.decided) begin
        $error("bit_res: expected %0d, actual %0d", s.decided, b);
        errors++;
      end
      if (sum !== s.total) begin
        $error("symbol_sum: expected %0d, actual %0d", s.total, sum);
        errors++;
      end
    endfunction

    function int pending();
      return symbols_due.size();
    endfunction
  endclass

  logic                           clk_i;
  logic                           rst_ni;
  logic                           cfg_we;
  logic [gdd_pkg::CFG_IDX_W-1:0]  cfg_idx;
  logic [gdd_pkg::CFG_DATA_W-1:0] cfg_data;

  gdd_in_if  in_if ();
  gdd_out_if out_if ();

  gmsk_discriminator_demod_core dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_if      (in_if.sink),
    .out_if     (out_if.source),
    .cfg_we_i   (cfg_we),
    .cfg_idx_i  (cfg_idx),
    .cfg_data_i (cfg_data)
  );

  demod_scoreboard symbols = new();

  int  burst_left = 0;
  int  rx_mode = 0;
  bit  hold_request = 0;
  real carrier_phase = 0.0;

  always begin
    clk_i = 1'b1;
    #5;
    clk_i = 1'b0;
    #5;
  end

  // receiver: stall pattern per mode, plus one long hold-off on demand
  initial begin
    int cyc;
    int hold_left;
    bit hold_taken;
    cyc = 0;
    hold_left = 0;
    hold_taken = 0;
    out_if.ready = 1'b0;
    forever begin
      @(negedge clk_i);
      cyc++;
      if (hold_request && !hold_taken) begin
        hold_left = 2500;
        hold_taken = 1;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_if.ready = 1'b0;
      end else begin
        case (rx_mode)
          0: out_if.ready = 1'b1;
          1: out_if.ready = (cyc % 11) >= 4;
          default: out_if.ready = $urandom_range(0, 99) >= 35;
        endcase
      end
    end
  end

  always @(posedge clk_i) begin
    if (out_if.valid && out_if.ready)
      symbols.check_result(out_if.bit_res, out_if.symbol_sum);
  end

  initial begin
    #20_000_000;
    $display("Regression FAIL");
    $finish;
  end

  task automatic send_request(demod_req_t q);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 40);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 60);
      if (gap > 0) begin
        @(negedge clk_i);
        in_if.valid = 1'b0;
        repeat (gap - 1) @(negedge clk_i);
      end
    end
    burst_left--;
    @(negedge clk_i);
    in_if.valid     = 1'b1;
    in_if.action    = q.is_load;
    in_if.i_sample  = q.i_val;
    in_if.q_sample  = q.q_val;
    in_if.tap_index = q.slot;
    in_if.tap_value = q.coef;
    do @(posedge clk_i); while (!in_if.ready);
    symbols.note_request(q);
  endtask

  task automatic send_iq(int iv, int qv);
    demod_req_t q;
    q.is_load = 0;
    q.i_val = gdd_pkg::SAMPLE_W'(iv);
    q.q_val = gdd_pkg::SAMPLE_W'(qv);
    q.slot = gdd_pkg::TIDX_W'($urandom);
    q.coef = gdd_pkg::TVAL_W'($urandom);
    send_request(q);
  endtask

  task automatic send_coef(int slot, int val);
    demod_req_t q;
    q.is_load = 1;
    q.i_val = gdd_pkg::SAMPLE_W'($urandom);
    q.q_val = gdd_pkg::SAMPLE_W'($urandom);
    q.slot = gdd_pkg::TIDX_W'(slot);
    q.coef = gdd_pkg::TVAL_W'(val);
    send_request(q);
  endtask

  task automatic write_reg(gdd_pkg::gdd_reg_e r, int unsigned v);
    @(negedge clk_i);
    in_if.valid = 1'b0;
    cfg_we = 1'b1;
    cfg_idx = r;
    cfg_data = gdd_pkg::CFG_DATA_W'(v);
    symbols.set_reg(r, v);
    @(negedge clk_i);
    cfg_we = 1'b0;
  endtask

  task automatic drain_symbols();
    @(negedge clk_i);
    in_if.valid = 1'b0;
    while (symbols.pending() != 0) @(posedge clk_i);
    // loads and non-boundary samples may still be in flight
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  // mostly a slowly turning phasor, some raw noise, some coefficient loads
  task automatic random_phase(int n, int tap_span);
    int   sel, amp;
    real  step;
    step = 0.3;
    for (int k = 0; k < n; k++) begin
      sel = $urandom_range(0, 99);
      if (sel < 12) begin
        if ($urandom_range(0, 3) == 0) send_coef($urandom, $urandom);
        else send_coef($urandom_range(0, tap_span - 1), $urandom_range(0, 32768));
      end else if (sel < 27) begin
        send_iq($signed(16'($urandom)), $signed(16'($urandom)));
      end else begin
        if ($urandom_range(0, 7) == 0) step = -step;
        carrier_phase += step * ($urandom_range(50, 150) / 100.0);
        amp = $urandom_range(64, 32767);
        send_iq($rtoi(amp * $cos(carrier_phase)), $rtoi(amp * $sin(carrier_phase)));
      end
    end
  endtask

  task automatic run_phase(int unsigned sps, int unsigned taps, int n, int span, int mode);
    drain_symbols();
    write_reg(gdd_pkg::REG_SPS, sps);
    write_reg(gdd_pkg::REG_TAPS, taps);
    rx_mode = mode;
    random_phase(n, span);
  endtask

  initial begin
    rst_ni = 1'b0;
    cfg_we = 1'b0;
    cfg_idx = gdd_pkg::REG_SPS;
    cfg_data = '0;
    in_if.valid = 1'b0;
    in_if.action = 1'b0;
    in_if.i_sample = '0;
    in_if.q_sample = '0;
    in_if.tap_index = '0;
    in_if.tap_value = '0;
    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // a few samples on the reset settings
    send_iq(1000, 0);
    send_iq(0, 1000);
    send_iq(-1000, 0);

    drain_symbols();
    write_reg(gdd_pkg::REG_SPS, 1);
    write_reg(gdd_pkg::REG_TAPS, 3);
    send_coef(0, 65535);
    send_coef(1, 32768);
    send_coef(2, 0);
    send_coef(511, 12345);
    send_iq(0, 0);
    send_iq(0, 0);
    send_iq(32767, 0);
    send_iq(-32768, 0);
    send_iq(-32768, -32768);
    send_iq(32767, -32768);
    send_iq(0, 32767);
    send_iq(0, -32768);
    send_iq(1, 1);
    send_iq(-1, 1);
    send_iq(-1, -1);
    send_iq(1, -1);
    send_iq(0, 0);
    send_iq(32767, 32767);

    run_phase(1, 1, 200, 4, 0);
    run_phase(3, 8, 300, 8, 1);
    run_phase(0, 0, 150, 2, 2);
    run_phase(16, 64, 260, 64, 2);
    run_phase(7, 512, 40, 512, 1);
    run_phase(4095, 1023, 30, 512, 0);

    // long receiver hold-off while requests keep coming
    drain_symbols();
    write_reg(gdd_pkg::REG_SPS, 2);
    write_reg(gdd_pkg::REG_TAPS, 5);
    rx_mode = 2;
    hold_request = 1;
    random_phase(170, 5);

    drain_symbols();
    if (symbols.errors == 0)
      $display("Regression PASS");
    else
      $display("Regression FAIL");
    $finish;
  end

endmodule

FILE: gmsk_discriminator_demod_core.f
src/gdd_pkg.sv
src/gdd_in_if.sv
src/gdd_out_if.sv
src/gdd_ctrl.sv
src/gdd_cordic.sv
src/gdd_datapath.sv
src/gmsk_discriminator_demod_core.sv
bench/gmsk_discriminator_demod_core_test.sv
